FILE: rtl/ansi_ecp_pkg.sv
package ansi_ecp_pkg;

    // Argument accumulators and cursor coordinate storage widths.
    localparam int ARG_WIDTH   = 16;
    localparam int COORD_WIDTH = 8;
    // Cursor arithmetic width: room for an 8-bit screen size plus one carry bit.
    localparam int CALC_W      = ((COORD_WIDTH > 8) ? COORD_WIDTH : 8) + 1;

    localparam logic [ARG_WIDTH-1:0] ARG_MAX = {ARG_WIDTH{1'b1}};

    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_FIN_H  = 8'h48;
    localparam logic [7:0] CH_FIN_J  = 8'h4A;
    localparam logic [7:0] CH_FIN_M  = 8'h6D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [7:0] ATTR_RESET  = 8'h1F;
    localparam logic [7:0] WIDTH_RESET = 8'd80;
    localparam logic [7:0] HEIGHT_RESET = 8'd25;

    // Configuration register indexes.
    localparam logic CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        PS_TEXT = 3'd0,
        PS_ESC  = 3'd1,
        PS_ARG1 = 3'd2,
        PS_ARG2 = 3'd3,
        PS_ARG3 = 3'd4
    } t_pstate;

    // Parser decision handed to the cursor unit.
    typedef struct packed {
        logic                 plain;
        logic                 clear;
        logic                 move;
        logic [ARG_WIDTH-1:0] row_arg;
        logic [ARG_WIDTH-1:0] col_arg;
    } t_pctl;

    // Cursor unit result fields.
    typedef struct packed {
        logic       draw_valid;
        logic [7:0] draw_char;
        logic [7:0] draw_col;
        logic [7:0] draw_row;
        logic [7:0] cursor_col;
        logic [7:0] cursor_row;
    } t_cres;

    function automatic logic [2:0] vga_map(input logic [2:0] c);
        logic [2:0] m;
        case (c)
            3'd0: m = 3'd0;
            3'd1: m = 3'd4;
            3'd2: m = 3'd2;
            3'd3: m = 3'd6;
            3'd4: m = 3'd1;
            3'd5: m = 3'd5;
            3'd6: m = 3'd3;
            default: m = 3'd7;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] apply_attr(input logic [7:0] attr,
                                              input logic [ARG_WIDTH-1:0] code);
        logic [7:0]           a;
        logic [ARG_WIDTH-1:0] off;
        a   = attr;
        off = '0;
        if (code == ARG_WIDTH'(0)) begin
            a[3] = 1'b0;
        end else if (code == ARG_WIDTH'(1)) begin
            a[3] = 1'b1;
        end else if (code >= ARG_WIDTH'(30) && code <= ARG_WIDTH'(37)) begin
            off    = code - ARG_WIDTH'(30);
            a[2:0] = vga_map(off[2:0]);
        end else if (code >= ARG_WIDTH'(40) && code <= ARG_WIDTH'(47)) begin
            off    = code - ARG_WIDTH'(40);
            a[6:4] = vga_map(off[2:0]);
        end
        return a;
    endfunction

    // acc * 10 + digit, saturating at ARG_MAX.
    function automatic logic [ARG_WIDTH-1:0] add_digit(input logic [ARG_WIDTH-1:0] acc,
                                                       input logic [7:0] ch);
        logic [ARG_WIDTH+3:0] ext;
        logic [ARG_WIDTH+3:0] v;
        ext = {4'b0000, acc};
        v   = (ext << 3) + (ext << 1) + (ARG_WIDTH+4)'(ch[3:0]);
        if (|v[ARG_WIDTH+3:ARG_WIDTH]) begin
            return ARG_MAX;
        end
        return v[ARG_WIDTH-1:0];
    endfunction

endpackage

FILE: rtl/ansi_escape_console_parser_unit.sv
// Console escape parser: one byte in, one result out.
// An accepted byte waits in the input register until the result stage can take its result.
// Throughput: one byte per cycle while results drain; the input register can take one more
// byte while a result waits, and a stalled result stops input once that register is full.
// Reset (synchronous, active low): plain-text state, cursor at 0,0, attribute 0x1F,
// screen 80 by 25, both pipeline stages empty.
module ansi_escape_console_parser_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write port
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data,
    // byte request channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_in,
    // result request channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_draw_valid,
    output logic [7:0] o_draw_char,
    output logic [7:0] o_draw_col,
    output logic [7:0] o_draw_row,
    output logic       o_clear_screen,
    output logic [7:0] o_cursor_col,
    output logic [7:0] o_cursor_row,
    output logic [7:0] o_text_attribute
);

    // Screen geometry registers.
    logic [7:0] r_width;
    logic [7:0] r_height;
    logic [7:0] width_eff;
    logic [7:0] height_eff;

    // Input stage: holds one accepted byte request.
    logic       r_in_valid;
    logic [7:0] r_char;

    // Result stage.
    logic                r_out_valid;
    ansi_ecp_pkg::t_cres r_res;
    logic                r_clear;
    logic [7:0]          r_attr;

    logic                advance;
    logic                proc;
    ansi_ecp_pkg::t_pctl ctl;
    ansi_ecp_pkg::t_cres cres;
    logic [7:0]          n_attr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= ansi_ecp_pkg::WIDTH_RESET;
            r_height <= ansi_ecp_pkg::HEIGHT_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                ansi_ecp_pkg::CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                ansi_ecp_pkg::CFG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A zero size behaves as a one-cell screen dimension.
    assign width_eff  = (r_width  == 8'd0) ? 8'd1 : r_width;
    assign height_eff = (r_height == 8'd0) ? 8'd1 : r_height;

    // The result stage can take a new result when empty or being drained.
    assign advance    = !r_out_valid || i_out_ready;
    // Process the held byte whenever the result stage frees up.
    assign proc       = r_in_valid && advance;
    // Refill the input stage when it is empty or emptying this cycle.
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_char <= i_char_in;
        end
    end

    // Escape sequence state, argument accumulators and attribute byte.
    ansi_ecp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (proc),
        .i_char  (r_char),
        .o_ctl   (ctl),
        .o_attr  (n_attr)
    );

    // Cursor tracking, wrap and clamp, draw request.
    ansi_ecp_cursor u_cursor (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (proc),
        .i_char   (r_char),
        .i_ctl    (ctl),
        .i_width  (width_eff),
        .i_height (height_eff),
        .o_res    (cres)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    // Capture the result along with the state update; hold it while stalled.
    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_res   <= cres;
            r_clear <= ctl.clear;
            r_attr  <= n_attr;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_draw_valid     = r_res.draw_valid;
    assign o_draw_char      = r_res.draw_char;
    assign o_draw_col       = r_res.draw_col;
    assign o_draw_row       = r_res.draw_row;
    assign o_clear_screen   = r_clear;
    assign o_cursor_col     = r_res.cursor_col;
    assign o_cursor_row     = r_res.cursor_row;
    assign o_text_attribute = r_attr;

endmodule

FILE: rtl/ansi_ecp_parser.sv
module ansi_ecp_parser (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic [7:0]                i_char,
    output ansi_ecp_pkg::t_pctl       o_ctl,
    output logic [7:0]                o_attr
);

    ansi_ecp_pkg::t_pstate r_state, n_state;
    logic [ansi_ecp_pkg::ARG_WIDTH-1:0] r_arg1, n_arg1;
    logic [ansi_ecp_pkg::ARG_WIDTH-1:0] r_arg2, n_arg2;
    logic [ansi_ecp_pkg::ARG_WIDTH-1:0] r_arg3, n_arg3;
    logic [7:0] r_attr, n_attr;
    logic       is_digit;

    assign is_digit = (i_char >= ansi_ecp_pkg::CH_ZERO) && (i_char <= ansi_ecp_pkg::CH_NINE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ansi_ecp_pkg::PS_TEXT;
            r_arg1  <= '0;
            r_arg2  <= '0;
            r_arg3  <= '0;
            r_attr  <= ansi_ecp_pkg::ATTR_RESET;
        end else if (i_en) begin
            r_state <= n_state;
            r_arg1  <= n_arg1;
            r_arg2  <= n_arg2;
            r_arg3  <= n_arg3;
            r_attr  <= n_attr;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_arg1        = r_arg1;
        n_arg2        = r_arg2;
        n_arg3        = r_arg3;
        n_attr        = r_attr;
        o_ctl.plain   = 1'b0;
        o_ctl.clear   = 1'b0;
        o_ctl.move    = 1'b0;
        o_ctl.row_arg = r_arg1;
        o_ctl.col_arg = r_arg2;

        unique case (r_state)
            ansi_ecp_pkg::PS_ESC: begin
                if (i_char == ansi_ecp_pkg::CH_LBRACK) begin
                    n_state = ansi_ecp_pkg::PS_ARG1;
                    n_arg1  = '0;
                end else begin
                    n_state     = ansi_ecp_pkg::PS_TEXT;
                    o_ctl.plain = 1'b1;
                end
            end
            ansi_ecp_pkg::PS_ARG1: begin
                if (is_digit) begin
                    n_arg1 = ansi_ecp_pkg::add_digit(r_arg1, i_char);
                end else if (i_char == ansi_ecp_pkg::CH_SEMI) begin
                    n_state = ansi_ecp_pkg::PS_ARG2;
                    n_arg2  = '0;
                end else begin
                    n_state = ansi_ecp_pkg::PS_TEXT;
                    if (i_char == ansi_ecp_pkg::CH_FIN_J
                            && r_arg1 == ansi_ecp_pkg::ARG_WIDTH'(2)) begin
                        o_ctl.clear = 1'b1;
                    end else if (i_char == ansi_ecp_pkg::CH_FIN_M) begin
                        n_attr = ansi_ecp_pkg::apply_attr(r_attr, r_arg1);
                    end
                end
            end
            ansi_ecp_pkg::PS_ARG2: begin
                if (is_digit) begin
                    n_arg2 = ansi_ecp_pkg::add_digit(r_arg2, i_char);
                end else if (i_char == ansi_ecp_pkg::CH_SEMI) begin
                    n_state = ansi_ecp_pkg::PS_ARG3;
                    n_arg3  = '0;
                end else begin
                    n_state = ansi_ecp_pkg::PS_TEXT;
                    if (i_char == ansi_ecp_pkg::CH_FIN_H) begin
                        o_ctl.move = 1'b1;
                    end else if (i_char == ansi_ecp_pkg::CH_FIN_M) begin
                        n_attr = ansi_ecp_pkg::apply_attr(
                                     ansi_ecp_pkg::apply_attr(r_attr, r_arg1), r_arg2);
                    end
                end
            end
            ansi_ecp_pkg::PS_ARG3: begin
                if (is_digit) begin
                    n_arg3 = ansi_ecp_pkg::add_digit(r_arg3, i_char);
                end else begin
                    n_state = ansi_ecp_pkg::PS_TEXT;
                    if (i_char == ansi_ecp_pkg::CH_FIN_M) begin
                        n_attr = ansi_ecp_pkg::apply_attr(
                                     ansi_ecp_pkg::apply_attr(
                                         ansi_ecp_pkg::apply_attr(r_attr, r_arg1),
                                         r_arg2),
                                     r_arg3);
                    end
                end
            end
            default: begin
                n_state     = ansi_ecp_pkg::PS_TEXT;
                o_ctl.plain = 1'b1;
            end
        endcase

        // ESC in plain text opens a new sequence.
        if (o_ctl.plain && i_char == ansi_ecp_pkg::CH_ESC) begin
            n_state = ansi_ecp_pkg::PS_ESC;
        end
    end

    assign o_attr = n_attr;

endmodule

FILE: rtl/ansi_ecp_cursor.sv
module ansi_ecp_cursor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic [7:0]          i_char,
    input  ansi_ecp_pkg::t_pctl i_ctl,
    input  logic [7:0]          i_width,
    input  logic [7:0]          i_height,
    output ansi_ecp_pkg::t_cres o_res
);

    logic [ansi_ecp_pkg::COORD_WIDTH-1:0] r_col, n_col;
    logic [ansi_ecp_pkg::COORD_WIDTH-1:0] r_row, n_row;
    logic [ansi_ecp_pkg::CALC_W-1:0]      col, row, w_ext, h_ext;
    logic [ansi_ecp_pkg::CALC_W-1:0]      mv_col, mv_row;
    logic [ansi_ecp_pkg::CALC_W-1:0]      out_col, out_row;
    logic                                 draw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_en) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign w_ext  = ansi_ecp_pkg::CALC_W'(i_width);
    assign h_ext  = ansi_ecp_pkg::CALC_W'(i_height);
    // A move target below the screen size always fits in 8 bits.
    assign mv_col = ansi_ecp_pkg::CALC_W'(i_ctl.col_arg[7:0]);
    assign mv_row = ansi_ecp_pkg::CALC_W'(i_ctl.row_arg[7:0]);

    always_comb begin
        col   = ansi_ecp_pkg::CALC_W'(r_col);
        row   = ansi_ecp_pkg::CALC_W'(r_row);
        n_col = r_col;
        n_row = r_row;
        draw  = 1'b0;

        if (i_ctl.clear) begin
            n_col = '0;
            n_row = '0;
        end else if (i_ctl.move) begin
            if (i_ctl.col_arg < ansi_ecp_pkg::ARG_WIDTH'(i_width)) begin
                n_col = mv_col[ansi_ecp_pkg::COORD_WIDTH-1:0];
            end
            if (i_ctl.row_arg < ansi_ecp_pkg::ARG_WIDTH'(i_height)) begin
                n_row = mv_row[ansi_ecp_pkg::COORD_WIDTH-1:0];
            end
        end else if (i_ctl.plain && i_char != ansi_ecp_pkg::CH_ESC) begin
            case (i_char)
                ansi_ecp_pkg::CH_BS: begin
                    if (col != '0) begin
                        col = col - ansi_ecp_pkg::CALC_W'(1);
                    end
                end
                ansi_ecp_pkg::CH_TAB: begin
                    col = {col[ansi_ecp_pkg::CALC_W-1:3] + (ansi_ecp_pkg::CALC_W-3)'(1), 3'b000};
                end
                ansi_ecp_pkg::CH_CR: begin
                    col = '0;
                end
                ansi_ecp_pkg::CH_LF: begin
                    col = '0;
                    row = row + ansi_ecp_pkg::CALC_W'(1);
                end
                default: begin
                    if (i_char >= ansi_ecp_pkg::CH_SPACE) begin
                        draw = 1'b1;
                        col  = col + ansi_ecp_pkg::CALC_W'(1);
                    end
                end
            endcase
            // wrap at the right edge, clamp at the last line
            if (col >= w_ext) begin
                col = '0;
                row = row + ansi_ecp_pkg::CALC_W'(1);
            end
            if (row >= h_ext) begin
                row = h_ext - ansi_ecp_pkg::CALC_W'(1);
            end
            n_col = col[ansi_ecp_pkg::COORD_WIDTH-1:0];
            n_row = row[ansi_ecp_pkg::COORD_WIDTH-1:0];
        end
    end

    assign out_col = ansi_ecp_pkg::CALC_W'(n_col);
    assign out_row = ansi_ecp_pkg::CALC_W'(n_row);

    always_comb begin
        o_res.draw_valid = draw;
        o_res.draw_char  = draw ? i_char : 8'h00;
        o_res.draw_col   = draw ? r_col : 8'h00;
        o_res.draw_row   = draw ? r_row : 8'h00;
        o_res.cursor_col = out_col[7:0];
        o_res.cursor_row = out_row[7:0];
    end

endmodule
